@@ design/zfa_pkg.sv @@
// ---------------------------------------------------------------------------
// Fibonacci-base adder package
// Shared widths, pipeline control word and elaboration-time weight helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package zfa_pkg;

   localparam int IN_DIGITS_DEF  = 39;
   localparam int OUT_DIGITS_DEF = 41;

   // Values up to twice the largest 39-digit operand and the weight F(43) fit here.
   localparam int VAL_W = 30;
   localparam int LEN_W = 6;
   localparam int PAT_W = 64;

   typedef struct packed {
      logic valid;
      logic sat_a;
      logic sat_b;
      logic sat_s;
   } zfa_ctl_type;

   // Weight of digit idx, which is F(idx+2): 1, 2, 3, 5, 8 and on.
   function automatic logic [VAL_W-1:0] zfa_weight(input int idx);
      logic [VAL_W-1:0] w0;
      logic [VAL_W-1:0] w1;
      logic [VAL_W-1:0] t;
      w0 = VAL_W'(1);
      w1 = VAL_W'(2);
      t  = '0;
      if (idx == 0) begin
         return w0;
      end
      for (int i = 1; i < idx; i++) begin
         t  = w0 + w1;
         w0 = w1;
         w1 = t;
      end
      return w1;
   endfunction

   // Largest canonical n-digit pattern: ones at n-1, n-3 and so on.
   function automatic logic [PAT_W-1:0] zfa_sat_pattern(input int n);
      logic [PAT_W-1:0] p;
      p = '0;
      for (int i = n - 1; i >= 0; i -= 2) begin
         p[i] = 1'b1;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

@@ design/zfa_eval_cell.sv @@
// ---------------------------------------------------------------------------
// Evaluation cell
// Adds the weight of one digit position to a running operand value and hands
// the value and the digit vector to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module zfa_eval_cell #(
   parameter int POS    = 0,
   parameter int DIGITS = zfa_pkg::IN_DIGITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     en_i,
   input  wire logic [DIGITS-1:0]        digits_i,
   input  wire logic [zfa_pkg::VAL_W-1:0] acc_i,
   output logic      [DIGITS-1:0]        digits_o,
   output logic      [zfa_pkg::VAL_W-1:0] acc_o
);
   import zfa_pkg::*;

   localparam logic [VAL_W-1:0] WEIGHT = zfa_weight(POS);

   logic [DIGITS-1:0] digits_ff;
   logic [VAL_W-1:0]  acc_ff;
   logic [VAL_W-1:0]  acc_in;

   assign acc_in = acc_i + (digits_i[POS] ? WEIGHT : '0);

   always_ff @(posedge clock) begin
      if (en_i) begin
         digits_ff <= digits_i;
         acc_ff    <= acc_in;
      end
   end

   assign digits_o = digits_ff;
   assign acc_o    = acc_ff;

endmodule

`default_nettype wire

@@ design/zfa_canon_cell.sv @@
// ---------------------------------------------------------------------------
// Canonical digit cell
// Decides one Zeckendorf digit greedily: takes the weight off the remainder
// when it fits, and notes the length at the first digit that is set.
// ---------------------------------------------------------------------------
`default_nettype none

module zfa_canon_cell #(
   parameter int POS    = 0,
   parameter int DIGITS = zfa_pkg::IN_DIGITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      en_i,
   input  wire logic [zfa_pkg::VAL_W-1:0] rem_i,
   input  wire logic [DIGITS-1:0]         bits_i,
   input  wire logic [zfa_pkg::LEN_W-1:0] len_i,
   output logic      [zfa_pkg::VAL_W-1:0] rem_o,
   output logic      [DIGITS-1:0]         bits_o,
   output logic      [zfa_pkg::LEN_W-1:0] len_o
);
   import zfa_pkg::*;

   logic [VAL_W-1:0]  rem_ff;
   logic [VAL_W-1:0]  rem_in;
   logic [DIGITS-1:0] bits_ff;
   logic [DIGITS-1:0] bits_in;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;

   generate
      if (POS < DIGITS) begin : g_digit
         localparam logic [VAL_W-1:0] WEIGHT  = zfa_weight(POS);
         localparam logic [LEN_W-1:0] LEN_POS = LEN_W'(POS + 1);
         logic hit;

         assign hit = (rem_i >= WEIGHT);

         always_comb begin
            bits_in      = bits_i;
            bits_in[POS] = hit;
            rem_in       = hit ? (rem_i - WEIGHT) : rem_i;
            len_in       = (hit && (len_i == '0)) ? LEN_POS : len_i;
         end
      end else begin : g_pass
         // Positions above this operand's width only keep the word moving.
         always_comb begin
            bits_in = bits_i;
            rem_in  = rem_i;
            len_in  = len_i;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en_i) begin
         rem_ff  <= rem_in;
         bits_ff <= bits_in;
         len_ff  <= len_in;
      end
   end

   assign rem_o  = rem_ff;
   assign bits_o = bits_ff;
   assign len_o  = len_ff;

endmodule

`default_nettype wire

@@ design/zfa_out_buf.sv @@
// ---------------------------------------------------------------------------
// Output buffer
// Two-entry queue between the digit pipeline and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module zfa_out_buf #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_i,
   input  wire logic [WIDTH-1:0] data_i,
   output logic                  full_o,
   output logic                  valid_o,
   input  wire logic             ready_i,
   output logic      [WIDTH-1:0] data_o
);

   logic [WIDTH-1:0] mem_ff [2];
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic             pop;

   assign valid_o = (count_ff != 2'd0);
   assign full_o  = (count_ff == 2'd2);
   assign pop     = valid_o && ready_i;
   assign data_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_i && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push_i) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push_i) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end

endmodule

`default_nettype wire

@@ design/fibonacci_base_add_normalize.sv @@
// ---------------------------------------------------------------------------
// Fibonacci-base adder with Zeckendorf normalization
// Evaluates two Fibonacci-digit operands, adds them and returns both
// operands and the sum in canonical form with their digit counts.
// ---------------------------------------------------------------------------
// The block takes one word per clock while req_ready is high and returns one
// word per clock while rsp_ready is high. A word passes through IN_DIGITS
// evaluation cells (one digit weight added per cell), one adder stage, one
// range-check stage and one canonical cell for each digit of the wider of
// IN_DIGITS and OUT_DIGITS (one greedy digit decision per cell, highest weight
// first), then lands in a two-entry output buffer. The whole row of cells
// advances together; req_ready drops only while both output buffer entries
// hold results that have not been taken. Values too large for their digit
// count come back as the largest canonical pattern of that width.
`default_nettype none

module fibonacci_base_add_normalize #(
   parameter int IN_DIGITS  = zfa_pkg::IN_DIGITS_DEF,
   parameter int OUT_DIGITS = zfa_pkg::OUT_DIGITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [IN_DIGITS-1:0]      req_a_digits,
   input  wire logic [IN_DIGITS-1:0]      req_b_digits,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic      [IN_DIGITS-1:0]      rsp_a_canonical,
   output logic      [zfa_pkg::LEN_W-1:0] rsp_a_length,
   output logic      [IN_DIGITS-1:0]      rsp_b_canonical,
   output logic      [zfa_pkg::LEN_W-1:0] rsp_b_length,
   output logic      [OUT_DIGITS-1:0]     rsp_sum_canonical,
   output logic      [zfa_pkg::LEN_W-1:0] rsp_sum_length
);
   import zfa_pkg::*;

   localparam int CN_CELLS = (OUT_DIGITS > IN_DIGITS) ? OUT_DIGITS : IN_DIGITS;
   localparam int STAGES   = IN_DIGITS + 2 + CN_CELLS;
   localparam int PREP2    = IN_DIGITS + 1;
   localparam int BUF_W    = 2 * IN_DIGITS + OUT_DIGITS + 3 * LEN_W;

   localparam logic [VAL_W-1:0]      LIMIT_IN  = zfa_weight(IN_DIGITS);
   localparam logic [VAL_W-1:0]      LIMIT_OUT = zfa_weight(OUT_DIGITS);
   localparam logic [PAT_W-1:0]      PAT_IN    = zfa_sat_pattern(IN_DIGITS);
   localparam logic [PAT_W-1:0]      PAT_OUT   = zfa_sat_pattern(OUT_DIGITS);
   localparam logic [IN_DIGITS-1:0]  SAT_IN    = PAT_IN[IN_DIGITS-1:0];
   localparam logic [OUT_DIGITS-1:0] SAT_OUT   = PAT_OUT[OUT_DIGITS-1:0];
   localparam logic [LEN_W-1:0]      LEN_IN    = LEN_W'(IN_DIGITS);
   localparam logic [LEN_W-1:0]      LEN_OUT   = LEN_W'(OUT_DIGITS);
   localparam logic [LEN_W-1:0]      LEN_ONE   = LEN_W'(1);

   logic adv;
   logic buf_full;
   logic push;

   zfa_ctl_type ctl_ff [STAGES];
   zfa_ctl_type ctl_in [STAGES];

   // Evaluation row.
   logic [VAL_W-1:0]     ev_a_acc [IN_DIGITS+1];
   logic [VAL_W-1:0]     ev_b_acc [IN_DIGITS+1];
   logic [IN_DIGITS-1:0] ev_a_dig [IN_DIGITS+1];
   logic [IN_DIGITS-1:0] ev_b_dig [IN_DIGITS+1];

   // Adder and range-check stages.
   logic [VAL_W-1:0] p1_a_ff;
   logic [VAL_W-1:0] p1_b_ff;
   logic [VAL_W-1:0] p1_s_ff;
   logic [VAL_W-1:0] p2_a_ff;
   logic [VAL_W-1:0] p2_b_ff;
   logic [VAL_W-1:0] p2_s_ff;

   // Canonical row.
   logic [VAL_W-1:0]      cn_a_rem  [CN_CELLS+1];
   logic [VAL_W-1:0]      cn_b_rem  [CN_CELLS+1];
   logic [VAL_W-1:0]      cn_s_rem  [CN_CELLS+1];
   logic [IN_DIGITS-1:0]  cn_a_bits [CN_CELLS+1];
   logic [IN_DIGITS-1:0]  cn_b_bits [CN_CELLS+1];
   logic [OUT_DIGITS-1:0] cn_s_bits [CN_CELLS+1];
   logic [LEN_W-1:0]      cn_a_len  [CN_CELLS+1];
   logic [LEN_W-1:0]      cn_b_len  [CN_CELLS+1];
   logic [LEN_W-1:0]      cn_s_len  [CN_CELLS+1];

   logic [IN_DIGITS-1:0]  fin_a_can;
   logic [IN_DIGITS-1:0]  fin_b_can;
   logic [OUT_DIGITS-1:0] fin_s_can;
   logic [LEN_W-1:0]      fin_a_len;
   logic [LEN_W-1:0]      fin_b_len;
   logic [LEN_W-1:0]      fin_s_len;
   logic [BUF_W-1:0]      buf_data;
   zfa_ctl_type           last;

   assign adv       = !buf_full;
   assign req_ready = adv;

   // Control word travels alongside the data; range flags join at the check stage.
   always_comb begin
      ctl_in[0]       = '0;
      ctl_in[0].valid = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end
      ctl_in[PREP2].sat_a = (p1_a_ff >= LIMIT_IN);
      ctl_in[PREP2].sat_b = (p1_b_ff >= LIMIT_IN);
      ctl_in[PREP2].sat_s = (p1_s_ff >= LIMIT_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   assign ev_a_acc[0] = '0;
   assign ev_b_acc[0] = '0;
   assign ev_a_dig[0] = req_a_digits;
   assign ev_b_dig[0] = req_b_digits;

   generate
      for (genvar j = 0; j < IN_DIGITS; j++) begin : g_eval
         zfa_eval_cell #(
            .POS    (j),
            .DIGITS (IN_DIGITS)
         ) u_eval_a (
            .clock    (clock),
            .en_i     (adv),
            .digits_i (ev_a_dig[j]),
            .acc_i    (ev_a_acc[j]),
            .digits_o (ev_a_dig[j+1]),
            .acc_o    (ev_a_acc[j+1])
         );
         zfa_eval_cell #(
            .POS    (j),
            .DIGITS (IN_DIGITS)
         ) u_eval_b (
            .clock    (clock),
            .en_i     (adv),
            .digits_i (ev_b_dig[j]),
            .acc_i    (ev_b_acc[j]),
            .digits_o (ev_b_dig[j+1]),
            .acc_o    (ev_b_acc[j+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_a_ff <= ev_a_acc[IN_DIGITS];
         p1_b_ff <= ev_b_acc[IN_DIGITS];
         p1_s_ff <= ev_a_acc[IN_DIGITS] + ev_b_acc[IN_DIGITS];
         p2_a_ff <= p1_a_ff;
         p2_b_ff <= p1_b_ff;
         p2_s_ff <= p1_s_ff;
      end
   end

   assign cn_a_rem[0]  = p2_a_ff;
   assign cn_b_rem[0]  = p2_b_ff;
   assign cn_s_rem[0]  = p2_s_ff;
   assign cn_a_bits[0] = '0;
   assign cn_b_bits[0] = '0;
   assign cn_s_bits[0] = '0;
   assign cn_a_len[0]  = '0;
   assign cn_b_len[0]  = '0;
   assign cn_s_len[0]  = '0;

   generate
      for (genvar k = 0; k < CN_CELLS; k++) begin : g_canon
         zfa_canon_cell #(
            .POS    (CN_CELLS - 1 - k),
            .DIGITS (IN_DIGITS)
         ) u_canon_a (
            .clock  (clock),
            .en_i   (adv),
            .rem_i  (cn_a_rem[k]),
            .bits_i (cn_a_bits[k]),
            .len_i  (cn_a_len[k]),
            .rem_o  (cn_a_rem[k+1]),
            .bits_o (cn_a_bits[k+1]),
            .len_o  (cn_a_len[k+1])
         );
         zfa_canon_cell #(
            .POS    (CN_CELLS - 1 - k),
            .DIGITS (IN_DIGITS)
         ) u_canon_b (
            .clock  (clock),
            .en_i   (adv),
            .rem_i  (cn_b_rem[k]),
            .bits_i (cn_b_bits[k]),
            .len_i  (cn_b_len[k]),
            .rem_o  (cn_b_rem[k+1]),
            .bits_o (cn_b_bits[k+1]),
            .len_o  (cn_b_len[k+1])
         );
         zfa_canon_cell #(
            .POS    (CN_CELLS - 1 - k),
            .DIGITS (OUT_DIGITS)
         ) u_canon_s (
            .clock  (clock),
            .en_i   (adv),
            .rem_i  (cn_s_rem[k]),
            .bits_i (cn_s_bits[k]),
            .len_i  (cn_s_len[k]),
            .rem_o  (cn_s_rem[k+1]),
            .bits_o (cn_s_bits[k+1]),
            .len_o  (cn_s_len[k+1])
         );
      end
   endgenerate

   // A value that never set a digit is zero and counts as one digit.
   assign last = ctl_ff[STAGES-1];

   always_comb begin
      fin_a_can = last.sat_a ? SAT_IN  : cn_a_bits[CN_CELLS];
      fin_b_can = last.sat_b ? SAT_IN  : cn_b_bits[CN_CELLS];
      fin_s_can = last.sat_s ? SAT_OUT : cn_s_bits[CN_CELLS];
      fin_a_len = last.sat_a ? LEN_IN :
                  ((cn_a_len[CN_CELLS] == '0) ? LEN_ONE : cn_a_len[CN_CELLS]);
      fin_b_len = last.sat_b ? LEN_IN :
                  ((cn_b_len[CN_CELLS] == '0) ? LEN_ONE : cn_b_len[CN_CELLS]);
      fin_s_len = last.sat_s ? LEN_OUT :
                  ((cn_s_len[CN_CELLS] == '0) ? LEN_ONE : cn_s_len[CN_CELLS]);
   end

   assign push = last.valid && adv;

   zfa_out_buf #(
      .WIDTH (BUF_W)
   ) u_out_buf (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  ({fin_a_can, fin_a_len, fin_b_can, fin_b_len, fin_s_can, fin_s_len}),
      .full_o  (buf_full),
      .valid_o (rsp_valid),
      .ready_i (rsp_ready),
      .data_o  (buf_data)
   );

   assign {rsp_a_canonical, rsp_a_length, rsp_b_canonical, rsp_b_length,
           rsp_sum_canonical, rsp_sum_length} = buf_data;

   // The row stalls only when the buffer holds results, never on its own.
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled while output buffer holds nothing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_sum_canonical & (rsp_sum_canonical >> 1)) == '0))
      else $error("sum result has adjacent ones");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_a_length != '0 && rsp_a_length <= LEN_IN &&
                     rsp_sum_length != '0 && rsp_sum_length <= LEN_OUT))
      else $error("result length out of range");

endmodule

`default_nettype wire
